@@ src/lpdf_pkg.sv @@
// shared constants, types and match functions for the line pattern display filter
// no dependencies; imported by line_pattern_display_filter
`default_nettype none

package lpdf_pkg;

	// longest pattern in bytes (1..8)
	localparam int PATTERN_BYTES = 8;
	localparam int NUM_PATTERNS  = 5;

	localparam int BYTE_W = 8;
	localparam int PAT_W  = BYTE_W * PATTERN_BYTES;
	localparam int WIN_W  = PAT_W;
	localparam int LEN_W  = 4;
	localparam int LENS_W = LEN_W * NUM_PATTERNS;
	localparam int CNT_W  = 4;
	localparam int DATA_W = 64;
	localparam int IDX_W  = 3;

	// filter modes
	typedef enum logic [1:0] {
		MODE_OPEN  = 2'd0,
		MODE_BLOCK = 2'd1,
		MODE_ALLOW = 2'd2,
		MODE_SHOW  = 2'd3
	} mode_t;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_MODE    = 3'd0,
		REG_LENGTHS = 3'd1,
		REG_PAT_A   = 3'd2,
		REG_PAT_B   = 3'd3,
		REG_PAT_C   = 3'd4,
		REG_PAT_D   = 3'd5,
		REG_PAT_E   = 3'd6
	} reg_idx_t;

	// length nibble limited to the pattern size
	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] nib);
		if (nib > LEN_W'(PATTERN_BYTES))
			return LEN_W'(PATTERN_BYTES);
		return nib;
	endfunction

	// pattern ends at the newest window byte; window byte 0 is the current byte
	function automatic logic pat_match(
		input logic [PAT_W-1:0] pat,
		input logic [LEN_W-1:0] len,
		input logic [WIN_W-1:0] win,
		input logic [CNT_W-1:0] cnt
	);
		logic hit;
		logic eq;
		hit = 1'b0;
		for (int l = 1; l <= PATTERN_BYTES; l++) begin
			eq = 1'b1;
			for (int j = 0; j < l; j++) begin
				if (pat[BYTE_W*j +: BYTE_W] != win[BYTE_W*(l-1-j) +: BYTE_W])
					eq = 1'b0;
			end
			if (len == LEN_W'(l) && cnt >= CNT_W'(l - 1) && eq)
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

`default_nettype wire

@@ src/line_pattern_display_filter.sv @@
// line pattern display filter: input register, pattern match against byte history,
// result register with show/hide verdict; depends on lpdf_pkg
// a line_end byte is held in the input register, then its verdict goes to the result register
// throughput: one byte per cycle; the input register advances unless it holds a line
// end while the result register is full and stalled
// reset: arst_n clears configuration, history, byte count, hit flags and all valid bits
`default_nettype none

module line_pattern_display_filter
	import lpdf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// byte channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BYTE_W-1:0] line_byte,
	input  wire logic              line_end,
	// result channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   show_line,
	output logic                   any_match,
	// configuration write channel
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [DATA_W-1:0] cfg_data
);

	// configuration registers
	mode_t                   mode_q;
	logic [LENS_W-1:0]       lens_q;
	logic [PAT_W-1:0]        pat_q [NUM_PATTERNS];

	// input stage
	logic                    valid_s1;
	logic [BYTE_W-1:0]       byte_s1;
	logic                    end_s1;

	// line state
	logic [WIN_W-1:0]        hist_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [NUM_PATTERNS-1:0] hits_q;

	// result register
	logic                    out_valid_q;
	logic                    show_q;
	logic                    any_q;

	logic                    advance;
	logic                    in_take;
	logic [WIN_W-1:0]        window;
	logic [NUM_PATTERNS-1:0] match;
	logic [NUM_PATTERNS-1:0] nonempty;
	logic [NUM_PATTERNS-1:0] hits_new;
	logic                    any_d;
	logic                    show_d;

	assign cfg_ready = 1'b1;

	// configuration write transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OPEN;
			lens_q <= '0;
			for (int k = 0; k < NUM_PATTERNS; k++)
				pat_q[k] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MODE:    mode_q <= mode_t'(cfg_data[1:0]);
				REG_LENGTHS: lens_q <= cfg_data[LENS_W-1:0];
				REG_PAT_A:   pat_q[0] <= cfg_data[PAT_W-1:0];
				REG_PAT_B:   pat_q[1] <= cfg_data[PAT_W-1:0];
				REG_PAT_C:   pat_q[2] <= cfg_data[PAT_W-1:0];
				REG_PAT_D:   pat_q[3] <= cfg_data[PAT_W-1:0];
				REG_PAT_E:   pat_q[4] <= cfg_data[PAT_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: a byte without line end never waits on the result side
	assign advance  = valid_s1 && !(end_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= line_byte;
			end_s1  <= line_end;
		end
	end

	// match all patterns against history plus current byte
	assign window = WIN_W'({hist_q, byte_s1});

	always_comb begin
		for (int k = 0; k < NUM_PATTERNS; k++) begin
			nonempty[k] = (lens_q[LEN_W*k +: LEN_W] != '0);
			match[k]    = pat_match(pat_q[k], clamp_len(lens_q[LEN_W*k +: LEN_W]),
				window, cnt_q);
		end
	end

	assign hits_new = hits_q | match;
	assign any_d    = |(hits_new & nonempty);

	// verdict
	always_comb begin
		unique case (mode_q)
			MODE_BLOCK: show_d = (nonempty == '0) ? 1'b1 : !any_d;
			MODE_ALLOW: show_d = (nonempty == '0) ? 1'b0 : any_d;
			MODE_OPEN,
			MODE_SHOW:  show_d = 1'b1;
			default:    show_d = 1'b1;
		endcase
	end

	// line state update, cleared at each line end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			cnt_q  <= '0;
			hits_q <= '0;
		end else if (advance) begin
			if (end_s1) begin
				hist_q <= '0;
				cnt_q  <= '0;
				hits_q <= '0;
			end else begin
				hist_q <= window;
				hits_q <= hits_new;
				if (cnt_q != '1)
					cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && end_s1) begin
			show_q <= show_d;
			any_q  <= any_d;
		end
	end

	assign out_valid = out_valid_q;
	assign show_line = show_q;
	assign any_match = any_q;

	// a line end clears the line state
	a_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		advance && end_s1 |=> cnt_q == '0 && hits_q == '0)
		else $error("line state not cleared after line end");

	// stalling the input implies a held byte
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && end_s1 && out_valid_q)
		else $error("input stalled without a pending line end");

	// a blocked line end stays in the input register
	a_end_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && end_s1 && $stable(byte_s1))
		else $error("blocked line end lost");

	// a result register left full keeps its payload
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(show_q) && $stable(any_q))
		else $error("stalled result changed");

endmodule

`default_nettype wire
